>>> sv/rtkt_pkg.sv
package rtkt_pkg;

	typedef enum logic [2:0] {
		KIND_INSERT = 3'd0,
		KIND_CHECK  = 3'd1,
		KIND_CLEAR  = 3'd2,
		KIND_LAP    = 3'd3,
		KIND_READ   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_RANGE   = 2'd1,
		STATUS_NO_QUAL = 2'd2
	} status_t;

	// One stored tag, bit order as kept in the table row.
	typedef struct packed {
		logic        valid;
		logic        mirror;
		logic [7:0]  car;
		logic [23:0] name;
	} tag_t;

	localparam logic [31:0] NO_TIME     = 32'hFFFF_FFFF;
	localparam logic [31:0] STEP_FRAMES = 32'd1800;
	localparam logic [31:0] FIRST_TIME  = 32'd7200;
	localparam logic [31:0] LAST_TIME   = 32'd25200;
	localparam logic [7:0]  FIRST_LETTER = 8'h41;

	// Bytes that follow the first zero byte of a name are forced to zero.
	function automatic logic [23:0] clean_name(input logic [23:0] raw);
		logic [23:0] res;
		res = raw;
		if (raw[7:0] == 8'd0) begin
			res = 24'd0;
		end else if (raw[15:8] == 8'd0) begin
			res = {16'd0, raw[7:0]};
		end
		return res;
	endfunction

endpackage

>>> sv/rtkt_req_if.sv
interface rtkt_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [3:0]  table_sel;
	logic [3:0]  read_rank;
	logic [31:0] time_value;
	logic [23:0] tag_name;
	logic [7:0]  tag_car;
	logic        tag_mirror;

	modport source (
		output valid, kind, table_sel, read_rank, time_value, tag_name, tag_car, tag_mirror,
		input  ready
	);
	modport sink (
		input  valid, kind, table_sel, read_rank, time_value, tag_name, tag_car, tag_mirror,
		output ready
	);
endinterface

>>> sv/rtkt_rsp_if.sv
interface rtkt_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [3:0]  rank_found;
	logic [31:0] entry_time;
	logic [23:0] entry_name;
	logic [7:0]  entry_car;
	logic        entry_mirror;
	logic        entry_valid;
	logic [31:0] lap_best;
	logic [3:0]  count_valid;

	modport source (
		output valid, status, rank_found, entry_time, entry_name, entry_car, entry_mirror,
		       entry_valid, lap_best, count_valid,
		input  ready
	);
	modport sink (
		input  valid, status, rank_found, entry_time, entry_name, entry_car, entry_mirror,
		       entry_valid, lap_best, count_valid,
		output ready
	);
endinterface

>>> sv/ranked_top_k_time_table.sv
// Ranked top-k time table: one table row per RAM word, read, updated and written back.
// An accepted item reads its row from the RAM, executes, and its result is registered in
// the output register; it waits while the previous result still sits in the output register.
// No new item is taken while one is in flight, as each does a single RAM read-modify-write.
// Reset (arst_n low) clears all control state at once; every row reads as its default
// contents until first written, so no clearing pass is needed and items are taken at once.
module ranked_top_k_time_table #(
	parameter int TABLES = 8,
	parameter int SLOTS  = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	rtkt_req_if.sink   req,
	rtkt_rsp_if.source rsp
);

	localparam int AW = (TABLES > 1) ? $clog2(TABLES) : 1;
	localparam int SW = $clog2(SLOTS);

	// One row holds a whole table: its times, tags, best lap and valid count.
	typedef struct packed {
		logic [3:0]                       count;
		logic [31:0]                      lap;
		rtkt_pkg::tag_t [SLOTS-1:0]       tags;
		logic [SLOTS-1:0][31:0]           times;
	} row_t;

	localparam int RW = $bits(row_t);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// Contents a row reads as until it is first written, built from the table index.
	function automatic row_t default_row(input logic [AW-1:0] t);
		row_t        r;
		logic [31:0] toff;
		logic [7:0]  letter;
		toff = 32'(t) * rtkt_pkg::STEP_FRAMES;
		r.count = 4'(SLOTS);
		r.lap   = 32'd0;
		for (int j = 0; j < SLOTS; j++) begin
			letter = rtkt_pkg::FIRST_LETTER + 8'(j);
			if (j < 9) begin
				r.times[j] = rtkt_pkg::FIRST_TIME + 32'(j) * rtkt_pkg::STEP_FRAMES + toff;
			end else begin
				r.times[j] = rtkt_pkg::LAST_TIME + 32'(j - 9) * rtkt_pkg::STEP_FRAMES + toff;
			end
			r.tags[j].valid  = 1'b1;
			r.tags[j].mirror = 1'b0;
			r.tags[j].car    = 8'(j % 4);
			r.tags[j].name   = {letter, letter, letter};
		end
		return r;
	endfunction

	state_t state_q;

	// Captured item.
	logic [2:0]  kind_q;
	logic [AW-1:0] addr_q;
	logic        tsel_ok_q;
	logic [3:0]  rrank_q;
	logic        rrank_ok_q;
	logic [31:0] time_q;
	logic [23:0] name_q;
	logic [7:0]  car_q;
	logic        mirror_q;

	// Marks rows that have been written since reset.
	logic [TABLES-1:0] row_init_q;

	// Output register.
	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [3:0]  rank_found_q;
	logic [31:0] entry_time_q;
	logic [23:0] entry_name_q;
	logic [7:0]  entry_car_q;
	logic        entry_mirror_q;
	logic        entry_valid_q;
	logic [31:0] lap_best_q;
	logic [3:0]  count_valid_q;

	logic        accept;
	logic        leave;
	logic [RW-1:0] ram_rdata;
	row_t        row_cur;
	row_t        row_new;
	logic [SLOTS-1:0] qual;
	logic        found;
	logic [SW-1:0] rank;
	rtkt_pkg::tag_t ins_tag;
	rtkt_pkg::tag_t rd_tag;
	logic [31:0] rd_time;

	logic [1:0]  status_d;
	logic [3:0]  rank_found_d;
	logic [31:0] entry_time_d;
	logic [23:0] entry_name_d;
	logic [7:0]  entry_car_d;
	logic        entry_mirror_d;
	logic        entry_valid_d;
	logic [31:0] lap_best_d;
	logic [3:0]  count_valid_d;

	// A new item is taken whenever no item is in flight; a waiting result does not block it.
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	// The item in flight finishes once the output register is free or being emptied.
	assign leave     = (state_q == ST_EXEC) && (!out_valid_q || rsp.ready);

	rtkt_ram #(
		.WIDTH(RW),
		.DEPTH(TABLES)
	) u_row_ram (
		.clk  (clk),
		.we   (leave && tsel_ok_q),
		.waddr(addr_q),
		.wdata(row_new),
		.re   (accept),
		.raddr(req.table_sel[AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q     <= req.kind;
			addr_q     <= req.table_sel[AW-1:0];
			tsel_ok_q  <= ({1'b0, req.table_sel} < 5'(TABLES));
			rrank_q    <= req.read_rank;
			rrank_ok_q <= (req.read_rank < 4'(SLOTS));
			time_q     <= req.time_value;
			name_q     <= req.tag_name;
			car_q      <= req.tag_car;
			mirror_q   <= req.tag_mirror;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_init_q <= '0;
		end else if (leave && tsel_ok_q) begin
			row_init_q[addr_q] <= 1'b1;
		end
	end

	// A row never written since reset reads as its default contents.
	always_comb begin
		if (tsel_ok_q && row_init_q[addr_q]) begin
			row_cur = row_t'(ram_rdata);
		end else begin
			row_cur = default_row(addr_q);
		end
	end

	// All slots are compared at once; the first slot that is empty or slower is the rank.
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			qual[i] = !row_cur.tags[i].valid || (time_q < row_cur.times[i]);
		end
		found = |qual;
		rank  = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (qual[i]) begin
				rank = SW'(i);
			end
		end
	end

	assign ins_tag = '{valid: 1'b1, mirror: mirror_q, car: car_q,
	                   name: rtkt_pkg::clean_name(name_q)};
	assign rd_tag  = row_cur.tags[rrank_q[SW-1:0]];
	assign rd_time = row_cur.times[rrank_q[SW-1:0]];

	// Row update and result for the item in flight.
	always_comb begin
		row_new        = row_cur;
		status_d       = rtkt_pkg::STATUS_OK;
		rank_found_d   = 4'd0;
		entry_time_d   = rtkt_pkg::NO_TIME;
		entry_name_d   = 24'd0;
		entry_car_d    = 8'd0;
		entry_mirror_d = 1'b0;
		entry_valid_d  = 1'b0;
		lap_best_d     = 32'd0;
		count_valid_d  = 4'd0;
		if (!tsel_ok_q) begin
			status_d = rtkt_pkg::STATUS_RANGE;
		end else begin
			case (rtkt_pkg::kind_t'(kind_q))
				rtkt_pkg::KIND_INSERT, rtkt_pkg::KIND_CHECK: begin
					if (!found) begin
						status_d = rtkt_pkg::STATUS_NO_QUAL;
					end else begin
						rank_found_d = 4'(rank);
						if (rtkt_pkg::kind_t'(kind_q) == rtkt_pkg::KIND_INSERT) begin
							// The entry at the rank and those below it move down one place; the last drops off.
							if (rank == '0) begin
								row_new.times[0] = time_q;
								row_new.tags[0]  = ins_tag;
							end
							for (int i = 1; i < SLOTS; i++) begin
								if (SW'(i) == rank) begin
									row_new.times[i] = time_q;
									row_new.tags[i]  = ins_tag;
								end else if (SW'(i) > rank) begin
									row_new.times[i] = row_cur.times[i-1];
									row_new.tags[i]  = row_cur.tags[i-1];
								end
							end
							if (row_cur.count < 4'(SLOTS)) begin
								row_new.count = row_cur.count + 4'd1;
							end
						end
					end
				end
				rtkt_pkg::KIND_CLEAR: begin
					// Stale times and tags stay; only the valid marks go.
					for (int i = 0; i < SLOTS; i++) begin
						row_new.tags[i].valid = 1'b0;
					end
					row_new.count = 4'd0;
					row_new.lap   = 32'd0;
				end
				rtkt_pkg::KIND_LAP: begin
					// A stored lap of zero means none, so any offer replaces it.
					if ((time_q < row_cur.lap) || (row_cur.lap == 32'd0)) begin
						row_new.lap = time_q;
					end
				end
				rtkt_pkg::KIND_READ: begin
					if (!rrank_ok_q) begin
						status_d = rtkt_pkg::STATUS_RANGE;
					end else if (rd_tag.valid) begin
						entry_time_d   = rd_time;
						entry_name_d   = rd_tag.name;
						entry_car_d    = rd_tag.car;
						entry_mirror_d = rd_tag.mirror;
						entry_valid_d  = 1'b1;
					end
				end
				default: begin
					status_d = rtkt_pkg::STATUS_RANGE;
				end
			endcase
			if (status_d != rtkt_pkg::STATUS_RANGE || rtkt_pkg::kind_t'(kind_q) ==
			    rtkt_pkg::KIND_READ) begin
				lap_best_d    = row_new.lap;
				count_valid_d = row_new.count;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			out_valid_q    <= 1'b0;
			status_q       <= 2'd0;
			rank_found_q   <= 4'd0;
			entry_time_q   <= 32'd0;
			entry_name_q   <= 24'd0;
			entry_car_q    <= 8'd0;
			entry_mirror_q <= 1'b0;
			entry_valid_q  <= 1'b0;
			lap_best_q     <= 32'd0;
			count_valid_q  <= 4'd0;
		end else begin
			// A finishing item refills the output register even while the old result leaves.
			if (leave) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (leave) begin
						state_q        <= ST_IDLE;
						status_q       <= status_d;
						rank_found_q   <= rank_found_d;
						entry_time_q   <= entry_time_d;
						entry_name_q   <= entry_name_d;
						entry_car_q    <= entry_car_d;
						entry_mirror_q <= entry_mirror_d;
						entry_valid_q  <= entry_valid_d;
						lap_best_q     <= lap_best_d;
						count_valid_q  <= count_valid_d;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = status_q;
	assign rsp.rank_found   = rank_found_q;
	assign rsp.entry_time   = entry_time_q;
	assign rsp.entry_name   = entry_name_q;
	assign rsp.entry_car    = entry_car_q;
	assign rsp.entry_mirror = entry_mirror_q;
	assign rsp.entry_valid  = entry_valid_q;
	assign rsp.lap_best     = lap_best_q;
	assign rsp.count_valid  = count_valid_q;

endmodule

>>> sv/rtkt_ram.sv
module rtkt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> tb/rtkt_checker.sv
`timescale 1ns / 100ps

module rtkt_checker #(
	parameter int TABLES = 8,
	parameter int SLOTS  = 10
) (
	input  logic clk,
	input  logic arst_n,
	rtkt_req_if  req,
	rtkt_rsp_if  rsp,
	output int   fail_count,
	output int   pending
);

	typedef struct packed {
		rtkt_pkg::status_t status;
		logic [3:0]  rank;
		logic [31:0] etime;
		logic [23:0] ename;
		logic [7:0]  ecar;
		logic        emirror;
		logic        evalid;
		logic [31:0] lap;
		logic [3:0]  count;
	} board_result_t;

	// Shadow copy of the time tables.
	logic [31:0]    slot_time [TABLES][SLOTS];
	rtkt_pkg::tag_t slot_tag [TABLES][SLOTS];
	logic [31:0]    fastest_lap [TABLES];
	logic [3:0]     entry_count [TABLES];
	board_result_t  expected_q [$];

	// A name keeps its bytes only up to the first zero byte.
	function automatic logic [23:0] tidy_name(input logic [23:0] raw);
		logic [23:0] keep;
		keep = '0;
		if (raw[7:0] != 8'd0) begin
			keep[7:0] = 8'hFF;
			if (raw[15:8] != 8'd0) begin
				keep[23:8] = 16'hFFFF;
			end
		end
		return raw & keep;
	endfunction

	task automatic load_defaults();
		logic [7:0]  letter;
		logic [31:0] base_time;
		for (int t = 0; t < TABLES; t++) begin
			for (int j = 0; j < SLOTS; j++) begin
				letter = rtkt_pkg::FIRST_LETTER + 8'(j);
				if (j < 9) begin
					base_time = rtkt_pkg::FIRST_TIME + 32'(j) * rtkt_pkg::STEP_FRAMES;
				end else begin
					base_time = rtkt_pkg::LAST_TIME + 32'(j - 9) * rtkt_pkg::STEP_FRAMES;
				end
				slot_time[t][j] = base_time + 32'(t) * rtkt_pkg::STEP_FRAMES;
				slot_tag[t][j] = '{valid: 1'b1, mirror: 1'b0, car: 8'(j % 4),
					name: {letter, letter, letter}};
			end
			fastest_lap[t] = '0;
			entry_count[t] = 4'(SLOTS);
		end
	endtask

	// First position whose entry is empty or slower; SLOTS if the time does not qualify.
	function automatic int rank_for(input int t, input logic [31:0] tv);
		for (int j = 0; j < SLOTS; j++) begin
			if (!slot_tag[t][j].valid || tv < slot_time[t][j]) begin
				return j;
			end
		end
		return SLOTS;
	endfunction

	function automatic board_result_t apply_item(input logic [2:0] k, input logic [3:0] tsel,
			input logic [3:0] rr, input logic [31:0] tv, input logic [23:0] nm,
			input logic [7:0] car, input logic mir);
		board_result_t res;
		int t;
		int r;
		res = '{status: rtkt_pkg::STATUS_OK, rank: '0, etime: rtkt_pkg::NO_TIME,
			ename: '0, ecar: '0, emirror: 1'b0, evalid: 1'b0, lap: '0, count: '0};
		if (int'(tsel) >= TABLES || k > rtkt_pkg::KIND_READ) begin
			res.status = rtkt_pkg::STATUS_RANGE;
			return res;
		end
		t = int'(tsel);
		case (rtkt_pkg::kind_t'(k))
			rtkt_pkg::KIND_INSERT, rtkt_pkg::KIND_CHECK: begin
				r = rank_for(t, tv);
				if (r >= SLOTS) begin
					res.status = rtkt_pkg::STATUS_NO_QUAL;
				end else begin
					res.rank = 4'(r);
					if (k == rtkt_pkg::KIND_INSERT) begin
						for (int i = SLOTS - 1; i > r; i--) begin
							slot_time[t][i] = slot_time[t][i - 1];
							slot_tag[t][i] = slot_tag[t][i - 1];
						end
						slot_time[t][r] = tv;
						slot_tag[t][r] = '{valid: 1'b1, mirror: mir, car: car,
							name: tidy_name(nm)};
						if (entry_count[t] < 4'(SLOTS)) begin
							entry_count[t] = entry_count[t] + 4'd1;
						end
					end
				end
			end
			rtkt_pkg::KIND_CLEAR: begin
				for (int j = 0; j < SLOTS; j++) begin
					slot_tag[t][j].valid = 1'b0;
				end
				entry_count[t] = '0;
				fastest_lap[t] = '0;
			end
			rtkt_pkg::KIND_LAP: begin
				if (fastest_lap[t] == 32'd0 || tv < fastest_lap[t]) begin
					fastest_lap[t] = tv;
				end
			end
			default: begin
				if (int'(rr) >= SLOTS) begin
					res.status = rtkt_pkg::STATUS_RANGE;
				end else if (slot_tag[t][rr].valid) begin
					res.etime = slot_time[t][rr];
					res.ename = slot_tag[t][rr].name;
					res.ecar = slot_tag[t][rr].car;
					res.emirror = slot_tag[t][rr].mirror;
					res.evalid = 1'b1;
				end
			end
		endcase
		res.lap = fastest_lap[t];
		res.count = entry_count[t];
		return res;
	endfunction

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got, inout int errs);
		if (got !== want) begin
			$display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		board_result_t want;
		int errs;
		if (!arst_n) begin
			load_defaults();
			expected_q.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			errs = 0;
			if (req.valid && req.ready) begin
				expected_q.push_back(apply_item(req.kind, req.table_sel, req.read_rank,
					req.time_value, req.tag_name, req.tag_car, req.tag_mirror));
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t ns: result expected none, got status %0h time %0h",
						$time, rsp.status, rsp.entry_time);
					errs = 1;
				end else begin
					want = expected_q.pop_front();
					check_field("status", 32'(want.status), 32'(rsp.status), errs);
					check_field("rank_found", 32'(want.rank), 32'(rsp.rank_found), errs);
					check_field("entry_time", want.etime, rsp.entry_time, errs);
					check_field("entry_name", 32'(want.ename), 32'(rsp.entry_name), errs);
					check_field("entry_car", 32'(want.ecar), 32'(rsp.entry_car), errs);
					check_field("entry_mirror", 32'(want.emirror), 32'(rsp.entry_mirror),
						errs);
					check_field("entry_valid", 32'(want.evalid), 32'(rsp.entry_valid), errs);
					check_field("lap_best", want.lap, rsp.lap_best, errs);
					check_field("count_valid", 32'(want.count), 32'(rsp.count_valid), errs);
				end
				fail_count <= fail_count + errs;
			end
			pending <= expected_q.size();
		end
	end

endmodule

>>> tb/tb_ranked_top_k_time_table.sv
`timescale 1ns / 100ps

module tb_ranked_top_k_time_table;

	localparam int TABLES = 8;
	localparam int SLOTS  = 10;

	// Kind codes the block does not define; they must come back as out of range.
	localparam logic [2:0] KIND_SPARE_LO = 3'd5;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;

	localparam int HALF_PERIOD  = 4;
	localparam int RESET_CYCLES = 6;
	localparam int RANDOM_ITEMS = 400;
	localparam int IDLE_PCT     = 17;
	// The sender stops idling for this range of random items.
	localparam int SEND_CALM_FIRST = 150;
	localparam int SEND_CALM_LAST  = 260;
	// Cycle windows of the response side: one long hold-off, then a stretch with no stalls.
	localparam int HOLD_START  = 250;
	localparam int HOLD_CYCLES = 120;
	localparam int RECV_CALM_FIRST = 500;
	localparam int RECV_CALM_LAST  = 800;
	localparam int DRAIN_CYCLES = 8;
	localparam int TIMEOUT_NS   = 200_000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   sent_by_kind [8];
	bit   sender_calm;

	rtkt_req_if req_ch ();
	rtkt_rsp_if rsp_ch ();

	ranked_top_k_time_table #(
		.TABLES(TABLES),
		.SLOTS(SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// The checker mirrors the tables, predicts every result and counts the mismatches.
	rtkt_checker #(
		.TABLES(TABLES),
		.SLOTS(SLOTS)
	) board_check (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	// Offers one item at a falling edge and returns at the falling edge after it was taken.
	// Random idle cycles come first unless the sender is in its calm stretch; valid only
	// drops while idling, so back-to-back items keep it high across the boundary.
	task automatic offer_item(input logic [2:0] k, input logic [3:0] tsel,
			input logic [3:0] rr, input logic [31:0] tv, input logic [23:0] nm,
			input logic [7:0] car, input logic mir);
		while (!sender_calm && $urandom_range(0, 99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= k;
		req_ch.table_sel <= tsel;
		req_ch.read_rank <= rr;
		req_ch.time_value <= tv;
		req_ch.tag_name <= nm;
		req_ch.tag_car <= car;
		req_ch.tag_mirror <= mir;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		sent_by_kind[k]++;
	endtask

	initial begin : stimulus
		logic [2:0]  k;
		logic [3:0]  tsel;
		logic [3:0]  rr;
		logic [31:0] tv;
		logic [23:0] nm;
		int          pick;
		int          total;
		int          spare;

		arst_n = 1'b0;
		sender_calm = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.kind = '0;
		req_ch.table_sel = '0;
		req_ch.read_rank = '0;
		req_ch.time_value = '0;
		req_ch.tag_name = '0;
		req_ch.tag_car = '0;
		req_ch.tag_mirror = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Entries loaded at reset, at the first and last table and the last rank.
		offer_item(rtkt_pkg::KIND_READ, 4'd0, 4'd0, '0, '0, '0, 1'b0);
		offer_item(rtkt_pkg::KIND_READ, 4'(TABLES - 1), 4'(SLOTS - 1), '0, '0, '0, 1'b0);
		// Read ranks past the end of a table are refused.
		offer_item(rtkt_pkg::KIND_READ, 4'd0, 4'(SLOTS), '0, '0, '0, 1'b0);
		offer_item(rtkt_pkg::KIND_READ, 4'd1, 4'hF, '0, '0, '0, 1'b0);
		// A table number past the last table is refused and changes nothing.
		offer_item(rtkt_pkg::KIND_CHECK, 4'hF, 4'd0, 32'd0, '0, '0, 1'b0);
		offer_item(rtkt_pkg::KIND_LAP, 4'(TABLES), 4'd0, 32'd100, '0, '0, 1'b0);

		// Rank checks: fastest possible time, a tie with the best entry (ties rank
		// behind), and the slowest time, which cannot beat a full table.
		offer_item(rtkt_pkg::KIND_CHECK, 4'd0, 4'd0, 32'd0, '0, '0, 1'b0);
		offer_item(rtkt_pkg::KIND_CHECK, 4'd0, 4'd0, rtkt_pkg::FIRST_TIME, '0, '0, 1'b0);
		offer_item(rtkt_pkg::KIND_CHECK, 4'd0, 4'd0, rtkt_pkg::NO_TIME, '0, '0, 1'b0);

		// Inserts: one that does not qualify, one at the top with every tag bit set,
		// and two whose names hold a zero byte, so the bytes after it must be dropped.
		offer_item(rtkt_pkg::KIND_INSERT, 4'd0, 4'd0, rtkt_pkg::NO_TIME, 24'h434241, 8'h01,
			1'b0);
		offer_item(rtkt_pkg::KIND_INSERT, 4'd0, 4'd0, 32'd0, 24'hFFFFFF, 8'hFF, 1'b1);
		offer_item(rtkt_pkg::KIND_INSERT, 4'd0, 4'd0, rtkt_pkg::FIRST_TIME + 32'd1,
			24'hFF00AB, 8'h12, 1'b0);
		offer_item(rtkt_pkg::KIND_INSERT, 4'd0, 4'd0, rtkt_pkg::FIRST_TIME + 32'd2,
			24'hABCD00, 8'h34, 1'b1);
		// The new entries at the top, and the last rank after the shifts.
		offer_item(rtkt_pkg::KIND_READ, 4'd0, 4'd0, '0, '0, '0, 1'b0);
		offer_item(rtkt_pkg::KIND_READ, 4'd0, 4'd2, '0, '0, '0, 1'b0);
		offer_item(rtkt_pkg::KIND_READ, 4'd0, 4'(SLOTS - 1), '0, '0, '0, 1'b0);

		// Lap offers: the first is always taken, a slower one is not, a faster one is.
		// A zero wipes the best lap, and then even the slowest time is taken.
		offer_item(rtkt_pkg::KIND_LAP, 4'd1, 4'd0, 32'h1234, '0, '0, 1'b0);
		offer_item(rtkt_pkg::KIND_LAP, 4'd1, 4'd0, 32'h2000, '0, '0, 1'b0);
		offer_item(rtkt_pkg::KIND_LAP, 4'd1, 4'd0, 32'h1000, '0, '0, 1'b0);
		offer_item(rtkt_pkg::KIND_LAP, 4'd1, 4'd0, 32'd0, '0, '0, 1'b0);
		offer_item(rtkt_pkg::KIND_LAP, 4'd1, 4'd0, rtkt_pkg::NO_TIME, '0, '0, 1'b0);

		// Clear a table; its entries read as empty, and then any time qualifies at the
		// top, even the slowest one, and the count restarts from one.
		offer_item(rtkt_pkg::KIND_CLEAR, 4'd2, 4'd0, '0, '0, '0, 1'b0);
		offer_item(rtkt_pkg::KIND_READ, 4'd2, 4'd0, '0, '0, '0, 1'b0);
		offer_item(rtkt_pkg::KIND_INSERT, 4'd2, 4'd0, rtkt_pkg::NO_TIME, 24'h5A5A5A, 8'h80,
			1'b1);
		offer_item(rtkt_pkg::KIND_READ, 4'd2, 4'd0, '0, '0, '0, 1'b0);

		// Kind codes that the block does not know.
		offer_item(KIND_SPARE_LO, 4'd0, 4'd0, 32'd5, '0, '0, 1'b0);
		offer_item(KIND_SPARE_HI, 4'd3, 4'd0, 32'd5, '0, '0, 1'b0);

		// Random part. Most items hit tables in range and most times lie near the
		// default times, so inserts keep qualifying and reshuffling the tables; the
		// multiples of the step time tie with stored entries, and clears keep emptying
		// tables so that inserts into partly empty tables happen throughout.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			sender_calm = (n >= SEND_CALM_FIRST && n < SEND_CALM_LAST);
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				k = rtkt_pkg::KIND_INSERT;
			end else if (pick < 50) begin
				k = rtkt_pkg::KIND_CHECK;
			end else if (pick < 54) begin
				k = rtkt_pkg::KIND_CLEAR;
			end else if (pick < 66) begin
				k = rtkt_pkg::KIND_LAP;
			end else if (pick < 96) begin
				k = rtkt_pkg::KIND_READ;
			end else begin
				k = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
			end
			if ($urandom_range(0, 9) == 0) begin
				tsel = 4'($urandom_range(TABLES, 15));
			end else begin
				tsel = 4'($urandom_range(0, TABLES - 1));
			end
			if ($urandom_range(0, 4) == 0) begin
				rr = 4'($urandom_range(0, 15));
			end else begin
				rr = 4'($urandom_range(0, SLOTS - 1));
			end
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				tv = 32'($urandom_range(0, 30000));
			end else if (pick < 65) begin
				tv = rtkt_pkg::STEP_FRAMES * 32'($urandom_range(0, 20));
			end else if (pick < 72) begin
				tv = ($urandom_range(0, 1) == 1) ? rtkt_pkg::NO_TIME : 32'd0;
			end else begin
				tv = $urandom();
			end
			for (int b = 0; b < 3; b++) begin
				nm[8 * b +: 8] = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
			end
			offer_item(k, tsel, rr, tv, nm, 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)));
		end
		req_ch.valid <= 1'b0;

		// Wait for the last results, then wait out the drain window in case the block
		// sends anything unexpected.
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		total = 0;
		foreach (sent_by_kind[i]) total += sent_by_kind[i];
		spare = 0;
		for (int c = KIND_SPARE_LO; c <= KIND_SPARE_HI; c++) begin
			spare += sent_by_kind[c];
		end
		$display("covered %0d items: %0d inserts, %0d rank checks, %0d clears, %0d lap offers,",
			total, sent_by_kind[rtkt_pkg::KIND_INSERT], sent_by_kind[rtkt_pkg::KIND_CHECK],
			sent_by_kind[rtkt_pkg::KIND_CLEAR], sent_by_kind[rtkt_pkg::KIND_LAP]);
		$display("  %0d reads, %0d unknown kinds; results held off %0d cycles once",
			sent_by_kind[rtkt_pkg::KIND_READ], spare, HOLD_CYCLES);
		if (fail_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Response side. It stalls at random, holds off completely for one long window so
	// that the block backs up and refuses items, and takes every result in another window.
	initial begin : response_side
		int cyc;
		cyc = 0;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES) begin
				rsp_ch.ready <= 1'b0;
			end else if (cyc >= RECV_CALM_FIRST && cyc < RECV_CALM_LAST) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// Watchdog: the run ends here only if the block stops making progress.
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("timeout with %0d results outstanding", pending);
		$display("end of test: mismatches");
		$finish;
	end

endmodule
